// ----- hw/rtl/mlsq_pkg.sv -----
// mlsq_pkg: shared widths, command and status codes, and the control
// groups passed between the list manager's sequencer and its stores.
// No dependencies.
`default_nettype none

package mlsq_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  localparam int LISTS_DEF     = 16;
  localparam int NODES_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // descriptor store: head and tail memories
  typedef struct packed {
    logic rd;
    logic wr_head;
    logic wr_tail;
  } desc_ctl_t;

  // node store: word and link memories
  typedef struct packed {
    logic rd;
    logic wr_word;
    logic wr_link;
  } node_ctl_t;

  // free node stack
  typedef struct packed {
    logic rd;
    logic take;
    logic give;
  } free_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mlsq_channels.sv -----
// mlsq_in_if and mlsq_out_if: valid/ready channels for command items
// and result items. Depends on mlsq_pkg.
`default_nettype none

interface mlsq_in_if;
  import mlsq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ID_W-1:0]    list_id;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output list_id, output value, input ready);
  modport sink   (input valid, input cmd, input list_id, input value, output ready);
endinterface

interface mlsq_out_if;
  import mlsq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mlsq_desc.sv -----
// mlsq_desc: per-list head and tail node pointers, one memory each,
// registered read. Depends on mlsq_pkg.
`default_nettype none

module mlsq_desc #(
  parameter int LISTS  = mlsq_pkg::LISTS_DEF,
  parameter int NODE_W = $clog2(mlsq_pkg::NODES_DEF)
) (
  input  logic                     clk,
  input  mlsq_pkg::desc_ctl_t      ctl,
  input  logic [$clog2(LISTS)-1:0] addr,
  input  logic [NODE_W-1:0]        head_wdata,
  input  logic [NODE_W-1:0]        tail_wdata,
  output logic [NODE_W-1:0]        head_rdata,
  output logic [NODE_W-1:0]        tail_rdata
);
  import mlsq_pkg::*;

  logic [NODE_W-1:0] head_mem [LISTS];
  logic [NODE_W-1:0] tail_mem [LISTS];
  logic [NODE_W-1:0] head_rd_r;
  logic [NODE_W-1:0] tail_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_head) begin
      head_mem[addr] <= head_wdata;
    end
    if (ctl.wr_tail) begin
      tail_mem[addr] <= tail_wdata;
    end
    // read data holds until the next read
    if (ctl.rd) begin
      head_rd_r <= head_mem[addr];
      tail_rd_r <= tail_mem[addr];
    end
  end

  assign head_rdata = head_rd_r;
  assign tail_rdata = tail_rd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mlsq_node.sv -----
// mlsq_node: node pool, a word memory and a link memory, each with one
// address and a registered read. Depends on mlsq_pkg.
`default_nettype none

module mlsq_node #(
  parameter int NODES     = mlsq_pkg::NODES_DEF,
  parameter int WORD_BITS = mlsq_pkg::WORD_BITS_DEF,
  parameter int NODE_W    = $clog2(mlsq_pkg::NODES_DEF)
) (
  input  logic                 clk,
  input  mlsq_pkg::node_ctl_t  ctl,
  input  logic [NODE_W-1:0]    word_addr,
  input  logic [WORD_BITS-1:0] word_wdata,
  input  logic [NODE_W-1:0]    link_addr,
  input  logic [NODE_W-1:0]    link_wdata,
  output logic [WORD_BITS-1:0] word_rdata,
  output logic [NODE_W-1:0]    link_rdata
);
  import mlsq_pkg::*;

  logic [WORD_BITS-1:0] word_mem [NODES];
  logic [NODE_W-1:0]    link_mem [NODES];
  logic [WORD_BITS-1:0] word_rd_r;
  logic [NODE_W-1:0]    link_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_word) begin
      word_mem[word_addr] <= word_wdata;
    end
    if (ctl.wr_link) begin
      link_mem[link_addr] <= link_wdata;
    end
    if (ctl.rd) begin
      word_rd_r <= word_mem[word_addr];
      link_rd_r <= link_mem[link_addr];
    end
  end

  assign word_rdata = word_rd_r;
  assign link_rdata = link_rd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mlsq_free.sv -----
// mlsq_free: stack of free node numbers with its fill count. A low-water
// mark stands in for the initial contents. Depends on mlsq_pkg.
`default_nettype none

module mlsq_free #(
  parameter int NODES  = mlsq_pkg::NODES_DEF,
  parameter int NODE_W = $clog2(mlsq_pkg::NODES_DEF),
  parameter int CNT_W  = $clog2(mlsq_pkg::NODES_DEF + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlsq_pkg::free_ctl_t ctl,
  input  logic [NODE_W-1:0]   give_node,
  output logic [NODE_W-1:0]   take_node,
  output logic [CNT_W-1:0]    count
);
  import mlsq_pkg::*;

  logic [NODE_W-1:0] stack_mem [NODES];
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  low_r, low_nxt;
  logic [CNT_W-1:0]  top_cnt;
  logic [NODE_W-1:0] top_pos;
  logic [NODE_W-1:0] rd_r;
  logic [NODE_W-1:0] pos_r;
  logic              fresh_r;

  assign top_cnt = total_r - CNT_W'(1);
  assign top_pos = top_cnt[NODE_W-1:0];

  // slots below the low-water mark were never overwritten and still hold
  // their own index
  always_comb begin
    total_nxt = total_r;
    low_nxt   = low_r;
    if (ctl.take) begin
      total_nxt = top_cnt;
      if (top_cnt < low_r) begin
        low_nxt = top_cnt;
      end
    end else if (ctl.give && (total_r < CNT_W'(NODES))) begin
      total_nxt = total_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CNT_W'(NODES);
      low_r   <= CNT_W'(NODES);
    end else begin
      total_r <= total_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.give && (total_r < CNT_W'(NODES))) begin
      stack_mem[total_r[NODE_W-1:0]] <= give_node;
    end
    if (ctl.rd) begin
      rd_r    <= stack_mem[top_pos];
      pos_r   <= top_pos;
      fresh_r <= (top_cnt < low_r);
    end
  end

  assign take_node = fresh_r ? pos_r : rd_r;
  assign count     = total_r;

endmodule

`default_nettype wire

// ----- hw/rtl/multi_list_stack_queue_manager.sv -----
// Multi-list stack/queue manager: up to LISTS lists, each created once as a
// stack or a queue, sharing a pool of NODES linked nodes handed out from a
// free stack. Each command item gives one result item. A command is taken
// only while the sequencer is idle; the head/tail, node and free stores are
// single-port memories with registered reads, so a command reads the list
// descriptor, then takes one step per further memory access: create, no-op,
// errors and stack pushes finish in the lookup step, a pop or a push onto a
// non-empty queue in a pop or link step; each later step waits while the
// previous result has not been taken. No clearing pass is needed after
// reset. Depends on mlsq_pkg, mlsq_channels, mlsq_desc, mlsq_node, mlsq_free.
`default_nettype none

module multi_list_stack_queue_manager #(
  parameter int LISTS     = mlsq_pkg::LISTS_DEF,
  parameter int NODES     = mlsq_pkg::NODES_DEF,
  parameter int WORD_BITS = mlsq_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mlsq_in_if.sink           in_item,
  mlsq_out_if.source        out_item
);
  import mlsq_pkg::*;

  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int LIST_W = $clog2(LISTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_LINK,
    S_POP
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [LIST_W-1:0]    lidx_r;
  logic                 id_ok_r;
  logic [VALUE_W-1:0]   val_r;
  logic [LISTS-1:0]     exists_r, exists_nxt;
  logic [LISTS-1:0]     stack_r, stack_nxt;
  logic [LISTS-1:0]     nonempty_r, nonempty_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]   out_popped_r, out_popped_nxt;

  logic                 accept;
  logic                 can_go;
  logic                 finish;
  status_t              fin_status;
  logic [VALUE_W-1:0]   fin_popped;

  desc_ctl_t            d_ctl;
  node_ctl_t            n_ctl;
  free_ctl_t            f_ctl;
  logic [LIST_W-1:0]    desc_addr;
  logic [NODE_W-1:0]    head_wdata, tail_wdata;
  logic [NODE_W-1:0]    head_rdata, tail_rdata;
  logic [NODE_W-1:0]    word_addr, link_addr, link_wdata;
  logic [WORD_BITS-1:0] word_wdata, word_rdata;
  logic [NODE_W-1:0]    link_rdata;
  logic [NODE_W-1:0]    take_node;
  logic [CNT_W-1:0]     free_count;
  logic                 is_last;

  assign accept = in_item.valid && (state_r == S_IDLE);
  // a finishing step may overwrite the result register only once it is free
  assign can_go = !out_valid_r || out_item.ready;
  // head equals tail: the popped node is the list's tail
  assign is_last = (head_rdata == tail_rdata);

  mlsq_desc #(.LISTS(LISTS), .NODE_W(NODE_W)) u_desc (
    .clk        (clk),
    .ctl        (d_ctl),
    .addr       (desc_addr),
    .head_wdata (head_wdata),
    .tail_wdata (tail_wdata),
    .head_rdata (head_rdata),
    .tail_rdata (tail_rdata)
  );

  mlsq_node #(.NODES(NODES), .WORD_BITS(WORD_BITS), .NODE_W(NODE_W)) u_node (
    .clk        (clk),
    .ctl        (n_ctl),
    .word_addr  (word_addr),
    .word_wdata (word_wdata),
    .link_addr  (link_addr),
    .link_wdata (link_wdata),
    .word_rdata (word_rdata),
    .link_rdata (link_rdata)
  );

  mlsq_free #(.NODES(NODES), .NODE_W(NODE_W), .CNT_W(CNT_W)) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (f_ctl),
    .give_node (head_rdata),
    .take_node (take_node),
    .count     (free_count)
  );

  always_comb begin
    state_nxt      = state_r;
    exists_nxt     = exists_r;
    stack_nxt      = stack_r;
    nonempty_nxt   = nonempty_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    finish         = 1'b0;
    fin_status     = ST_OK;
    fin_popped     = '0;
    d_ctl          = '0;
    n_ctl          = '0;
    f_ctl          = '0;
    desc_addr      = lidx_r;
    head_wdata     = take_node;
    tail_wdata     = take_node;
    word_addr      = take_node;
    word_wdata     = WORD_BITS'(val_r);
    link_addr      = take_node;
    link_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          d_ctl.rd  = 1'b1;
          f_ctl.rd  = 1'b1;
          desc_addr = LIST_W'(in_item.list_id);
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (can_go) begin
          if (cmd_r == CMD_NOP) begin
            finish = 1'b1;
          end else if (!id_ok_r) begin
            finish     = 1'b1;
            fin_status = ST_MISSING;
          end else if (cmd_r == CMD_CREATE) begin
            finish = 1'b1;
            if (exists_r[lidx_r]) begin
              fin_status = ST_EXISTS;
            end else begin
              exists_nxt[lidx_r]   = 1'b1;
              stack_nxt[lidx_r]    = val_r[0];
              nonempty_nxt[lidx_r] = 1'b0;
            end
          end else if (cmd_r == CMD_PUSH) begin
            if (!exists_r[lidx_r]) begin
              finish     = 1'b1;
              fin_status = ST_MISSING;
            end else if (free_count == '0) begin
              finish     = 1'b1;
              fin_status = ST_FULL;
            end else begin
              f_ctl.take    = 1'b1;
              n_ctl.wr_word = 1'b1;
              n_ctl.wr_link = 1'b1;
              if (!nonempty_r[lidx_r]) begin
                d_ctl.wr_head        = 1'b1;
                d_ctl.wr_tail        = 1'b1;
                nonempty_nxt[lidx_r] = 1'b1;
                finish               = 1'b1;
              end else if (stack_r[lidx_r]) begin
                link_wdata    = head_rdata;
                d_ctl.wr_head = 1'b1;
                finish        = 1'b1;
              end else begin
                // queue: old tail gets linked to the new node next
                state_nxt = S_LINK;
              end
            end
          end else begin
            if (!exists_r[lidx_r]) begin
              finish     = 1'b1;
              fin_status = ST_MISSING;
            end else if (!nonempty_r[lidx_r]) begin
              finish     = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              n_ctl.rd  = 1'b1;
              word_addr = head_rdata;
              link_addr = head_rdata;
              state_nxt = S_POP;
            end
          end
        end
      end
      S_LINK: begin
        if (can_go) begin
          n_ctl.wr_link = 1'b1;
          link_addr     = tail_rdata;
          link_wdata    = take_node;
          d_ctl.wr_tail = 1'b1;
          finish        = 1'b1;
        end
      end
      S_POP: begin
        if (can_go) begin
          fin_popped = VALUE_W'(word_rdata);
          f_ctl.give = 1'b1;
          finish     = 1'b1;
          if (is_last) begin
            nonempty_nxt[lidx_r] = 1'b0;
          end else begin
            d_ctl.wr_head = 1'b1;
            head_wdata    = link_rdata;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_popped_nxt = fin_popped;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exists_r    <= '0;
      stack_r     <= '0;
      nonempty_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exists_r    <= exists_nxt;
      stack_r     <= stack_nxt;
      nonempty_r  <= nonempty_nxt;
    end
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    if (accept) begin
      cmd_r   <= cmd_t'(in_item.cmd);
      lidx_r  <= LIST_W'(in_item.list_id);
      id_ok_r <= (32'(in_item.list_id) < 32'(LISTS));
      val_r   <= in_item.value;
    end
  end

  assign in_item.ready         = (state_r == S_IDLE);
  assign out_item.valid        = out_valid_r;
  assign out_item.status       = out_status_r;
  assign out_item.popped_value = out_popped_r;

endmodule

`default_nettype wire
